### sv/fbpa_pkg.sv
// Shared constants, command and status codes for the fixed block pool allocator.
// No dependencies; used by sv/fixed_block_pool_allocator.sv.
package fbpa_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int BB_W       = 13;
	localparam int BIU_W      = 7;
	localparam int ADDR_W     = 32;
	localparam int SPAN_W     = CNT_W + BB_W;
	localparam int PROD_W     = IDX_W + BB_W;
	localparam int DB_W       = (IDX_W > 1) ? $clog2(IDX_W) : 1;
	localparam int CHUNK      = 16;
	localparam int CB_W       = 4;
	localparam int NCHUNK     = (MAX_BLOCKS + CHUNK - 1) / CHUNK;
	localparam int CH_W       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int PAD_N      = NCHUNK * CHUNK;
	localparam int PI_W       = CH_W + CB_W;

	localparam int IN_W       = 40;
	localparam int OUT_W      = 56;

	typedef enum logic [2:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_MEMBER = 3'd2,
		CMD_COUNT  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_OUTSIDE    = 3'd2,
		ST_MISALIGNED = 3'd3,
		ST_DOUBLE     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_POOL_BASE     = 2'd0,
		REG_BLOCK_BYTES   = 2'd1,
		REG_BLOCKS_IN_USE = 2'd2
	} reg_idx_t;

endpackage

### sv/fixed_block_pool_allocator.sv
// Fixed block pool allocator: used-flag map, sequencer, chunked scan/count and divider.
// Depends on sv/fbpa_pkg.sv.
//
// Usage: one command word enters on s_tvalid/s_tready, one result word leaves on
// m_tvalid/m_tready. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle; the block itself does not enforce this.
// Index 0 pool_base, 1 block_bytes, 2 blocks_in_use.
// The used map is scanned and counted 16 flags per cycle, and a free divides the pool
// offset by block_bytes one quotient bit per cycle.
// One command is in flight at a time; s_tready is high only while idle, which begins
// in the cycle after the previous result has been registered.
// The result register holds its word while m_tready is low; a finished command
// waits in its last state until the register is free, and no new word is taken.
// Reset clears the map (all blocks free), sets pool_base 0, block_bytes 1,
// blocks_in_use 64, and empties the result register.
module fixed_block_pool_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [2:0] command, [34:3] address, [39:35] zero
	input  logic [fbpa_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [2:0] status, [8:3] block_index, [40:9] block_address, [41] is_member,
	// [48:42] free_blocks, [55:49] zero
	output logic [fbpa_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_SPAN, S_DISPATCH, S_SCAN, S_MUL, S_ADD, S_DIV, S_CHECK, S_COUNT, S_DONE
	} state_t;

	localparam int RES_W = 3 + fbpa_pkg::IDX_W + fbpa_pkg::ADDR_W + 1 + fbpa_pkg::CNT_W;

	state_t                           state_q;
	fbpa_pkg::cmd_t                   cmd_q;
	fbpa_pkg::status_t                status_q;
	logic [fbpa_pkg::ADDR_W-1:0]      pool_base_q;
	logic [fbpa_pkg::BB_W-1:0]        block_bytes_q;
	logic [fbpa_pkg::BIU_W-1:0]       blocks_in_use_q;
	logic [fbpa_pkg::MAX_BLOCKS-1:0]  used_q;
	logic [fbpa_pkg::ADDR_W-1:0]      addr_q;
	logic [fbpa_pkg::ADDR_W-1:0]      off_q;
	logic [fbpa_pkg::CNT_W-1:0]       n_q;
	logic [fbpa_pkg::SPAN_W-1:0]      span_q;
	logic                             member_q;
	logic                             found_q;
	logic [fbpa_pkg::IDX_W-1:0]       idx_q;
	logic [fbpa_pkg::CH_W-1:0]        chunk_q;
	logic [fbpa_pkg::SPAN_W-1:0]      rem_q;
	logic [fbpa_pkg::IDX_W-1:0]       quo_q;
	logic [fbpa_pkg::DB_W-1:0]        bit_q;
	logic [fbpa_pkg::PROD_W-1:0]      prod_q;
	logic [fbpa_pkg::ADDR_W-1:0]      baddr_q;
	logic [fbpa_pkg::CNT_W-1:0]       free_q;
	logic                             m_tvalid_q;
	logic [fbpa_pkg::OUT_W-1:0]       m_tdata_q;

	logic [fbpa_pkg::PAD_N-1:0]       used_pad;
	logic [fbpa_pkg::CHUNK-1:0]       cand;
	logic                             cand_any;
	logic [fbpa_pkg::PI_W-1:0]        cand_first;
	logic                             member;
	logic [fbpa_pkg::SPAN_W-1:0]      div_d;
	logic                             div_ge;
	logic [fbpa_pkg::BIU_W-1:0]       in_biu;
	logic [RES_W-1:0]                 result;

	assign used_pad = fbpa_pkg::PAD_N'(used_q);
	assign in_biu   = blocks_in_use_q;

	// free flags of the current 16-flag chunk that lie inside the pool
	always_comb begin
		logic [fbpa_pkg::PI_W-1:0] bi;
		cand       = '0;
		cand_any   = 1'b0;
		cand_first = '0;
		for (int b = fbpa_pkg::CHUNK - 1; b >= 0; b--) begin
			bi = {chunk_q, fbpa_pkg::CB_W'(b)};
			cand[b] = !used_pad[bi] && (32'(bi) < 32'(n_q));
			if (cand[b]) begin
				cand_any   = 1'b1;
				cand_first = bi;
			end
		end
	end

	assign member = fbpa_pkg::ADDR_W'(span_q) > off_q;
	assign div_d  = fbpa_pkg::SPAN_W'(block_bytes_q) << bit_q;
	assign div_ge = rem_q >= div_d;

	assign result = {free_q, member_q, baddr_q, idx_q, status_q};

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			pool_base_q     <= '0;
			block_bytes_q   <= fbpa_pkg::BB_W'(1);
			blocks_in_use_q <= fbpa_pkg::BIU_W'(64);
			used_q          <= '0;
			m_tvalid_q      <= 1'b0;
			cmd_q           <= fbpa_pkg::CMD_ALLOC;
			status_q        <= fbpa_pkg::ST_OK;
			chunk_q         <= '0;
			bit_q           <= '0;
			found_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fbpa_pkg::REG_POOL_BASE:     pool_base_q     <= cfg_data;
					fbpa_pkg::REG_BLOCK_BYTES:   block_bytes_q   <= cfg_data[fbpa_pkg::BB_W-1:0];
					fbpa_pkg::REG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data[fbpa_pkg::BIU_W-1:0];
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q    <= fbpa_pkg::cmd_t'(s_tdata[2:0]);
						addr_q   <= s_tdata[34:3];
						off_q    <= s_tdata[34:3] - pool_base_q;
						n_q      <= (32'(in_biu) > 32'(fbpa_pkg::MAX_BLOCKS)) ?
							fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) : fbpa_pkg::CNT_W'(in_biu);
						status_q <= fbpa_pkg::ST_OK;
						idx_q    <= '0;
						baddr_q  <= '0;
						found_q  <= 1'b0;
						chunk_q  <= '0;
						free_q   <= '0;
						quo_q    <= '0;
						state_q  <= S_SPAN;
					end
				end
				S_SPAN: begin
					span_q  <= fbpa_pkg::SPAN_W'(n_q) * fbpa_pkg::SPAN_W'(block_bytes_q);
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					member_q <= member;
					case (cmd_q)
						fbpa_pkg::CMD_ALLOC: state_q <= S_SCAN;
						fbpa_pkg::CMD_FREE: begin
							if (!member) begin
								status_q <= fbpa_pkg::ST_OUTSIDE;
								state_q  <= S_COUNT;
							end else begin
								rem_q   <= off_q[fbpa_pkg::SPAN_W-1:0];
								bit_q   <= fbpa_pkg::DB_W'(fbpa_pkg::IDX_W - 1);
								state_q <= S_DIV;
							end
						end
						fbpa_pkg::CMD_CLEAR: begin
							used_q  <= '0;
							state_q <= S_COUNT;
						end
						default: state_q <= S_COUNT;
					endcase
				end
				S_SCAN: begin
					if (!found_q && cand_any) begin
						found_q <= 1'b1;
						idx_q   <= fbpa_pkg::IDX_W'(cand_first);
					end
					if (32'(chunk_q) == fbpa_pkg::NCHUNK - 1) begin
						chunk_q <= '0;
						state_q <= S_MUL;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_MUL: begin
					if (found_q) begin
						used_q[idx_q] <= 1'b1;
						prod_q  <= fbpa_pkg::PROD_W'(idx_q) * fbpa_pkg::PROD_W'(block_bytes_q);
						state_q <= S_ADD;
					end else begin
						status_q <= fbpa_pkg::ST_FULL;
						state_q  <= S_COUNT;
					end
				end
				S_ADD: begin
					baddr_q <= pool_base_q + fbpa_pkg::ADDR_W'(prod_q);
					state_q <= S_COUNT;
				end
				S_DIV: begin
					if (div_ge) begin
						rem_q        <= rem_q - div_d;
						quo_q[bit_q] <= 1'b1;
					end
					if (bit_q == '0) begin
						state_q <= S_CHECK;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_CHECK: begin
					if (rem_q != '0) begin
						status_q <= fbpa_pkg::ST_MISALIGNED;
					end else begin
						idx_q   <= quo_q;
						baddr_q <= addr_q;
						if (!used_q[quo_q]) begin
							status_q <= fbpa_pkg::ST_DOUBLE;
						end else begin
							used_q[quo_q] <= 1'b0;
							status_q      <= fbpa_pkg::ST_OK;
						end
					end
					chunk_q <= '0;
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					free_q <= free_q + fbpa_pkg::CNT_W'($countones(cand));
					if (32'(chunk_q) == fbpa_pkg::NCHUNK - 1) begin
						chunk_q <= '0;
						state_q <= S_DONE;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= fbpa_pkg::OUT_W'(result);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_full_means_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == fbpa_pkg::ST_FULL) |-> (m_tdata[48:42] == '0))
		else $error("pool full reported with free blocks");

	a_misaligned_is_member: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == fbpa_pkg::ST_MISALIGNED) |-> m_tdata[41])
		else $error("misaligned reported for address outside pool");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while command in flight");

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[48:42]) <= fbpa_pkg::MAX_BLOCKS))
		else $error("free count exceeds pool size");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for fixed_block_pool_allocator: a directed table, then random commands under
// random pool settings; each result word is checked against the table or a used-map model.
// Depends on sv/fbpa_pkg.sv and sv/fixed_block_pool_allocator.sv.
module tb;

	localparam logic [2:0] CMD_RSVD_LO = 3'd5;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_WORDS  = 105;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int CALM_LO      = 500;
	localparam int CALM_HI      = 700;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		fbpa_pkg::status_t           status;
		logic [fbpa_pkg::IDX_W-1:0]  index;
		logic [fbpa_pkg::ADDR_W-1:0] addr;
		logic                        member;
		logic [fbpa_pkg::CNT_W-1:0]  free;
	} pool_result_t;

	typedef struct {
		bit           is_cfg;
		logic [31:0]  base;
		logic [12:0]  bytes;
		logic [6:0]   count;
		logic [2:0]   cmd;
		logic [31:0]  addr;
		bit           typed;
		pool_result_t want;
	} plan_row_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [fbpa_pkg::IN_W-1:0]   s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [fbpa_pkg::OUT_W-1:0]  m_tdata;
	logic                        cfg_we = 1'b0;
	logic [1:0]                  cfg_index = '0;
	logic [31:0]                 cfg_data = '0;

	// model of the pool as the block should see it
	logic [31:0]                   map_base = '0;
	logic [12:0]                   map_bytes = 13'd1;
	logic [6:0]                    map_blocks = 7'd64;
	bit [fbpa_pkg::MAX_BLOCKS-1:0] block_taken = '0;

	pool_result_t alloc_replies_due[$];
	plan_row_t    directed_plan[$];
	int           bad_words = 0;
	int           words_sent = 0;
	int           quiet_cycles = 0;

	fixed_block_pool_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned pool_blocks();
		return (map_blocks > fbpa_pkg::MAX_BLOCKS) ? fbpa_pkg::MAX_BLOCKS : map_blocks;
	endfunction

	function automatic pool_result_t pool_predict(logic [2:0] cmd, logic [31:0] addr);
		pool_result_t r;
		int unsigned n, k;
		logic [31:0] offset;
		logic [63:0] span;
		bit found;
		r = '{fbpa_pkg::ST_OK, '0, '0, 1'b0, '0};
		n = pool_blocks();
		offset = addr - map_base;
		span = 64'(n) * 64'(map_bytes);
		r.member = {32'd0, offset} < span;
		found = 1'b0;
		case (cmd)
		fbpa_pkg::CMD_ALLOC: begin
			r.status = fbpa_pkg::ST_FULL;
			for (int i = 0; i < n; i++) begin
				if (!found && !block_taken[i]) begin
					found = 1'b1;
					block_taken[i] = 1'b1;
					r.status = fbpa_pkg::ST_OK;
					r.index = fbpa_pkg::IDX_W'(i);
					r.addr = map_base + 32'(i) * 32'(map_bytes);
				end
			end
		end
		fbpa_pkg::CMD_FREE: begin
			if (!r.member) begin
				r.status = fbpa_pkg::ST_OUTSIDE;
			end else if (offset % 32'(map_bytes) != 0) begin
				r.status = fbpa_pkg::ST_MISALIGNED;
			end else begin
				k = offset / 32'(map_bytes);
				if (k >= fbpa_pkg::MAX_BLOCKS) begin
					r.status = fbpa_pkg::ST_OUTSIDE;
				end else begin
					r.index = fbpa_pkg::IDX_W'(k);
					r.addr = addr;
					if (!block_taken[k]) begin
						r.status = fbpa_pkg::ST_DOUBLE;
					end else begin
						block_taken[k] = 1'b0;
					end
				end
			end
		end
		fbpa_pkg::CMD_CLEAR: block_taken = '0;
		default: ;
		endcase
		for (int i = 0; i < n; i++)
			if (!block_taken[i])
				r.free = r.free + 1'b1;
		return r;
	endfunction

	function automatic void plan_cfg(logic [31:0] base, logic [12:0] bytes, logic [6:0] count);
		plan_row_t row;
		row = '{1'b1, base, bytes, count, '0, '0, 1'b0, '0};
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_word(logic [2:0] cmd, logic [31:0] addr);
		plan_row_t row;
		row = '{1'b0, '0, '0, '0, cmd, addr, 1'b0, '0};
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_known(logic [2:0] cmd, logic [31:0] addr,
			fbpa_pkg::status_t st, logic [fbpa_pkg::IDX_W-1:0] idx, logic [31:0] baddr,
			logic mem, logic [fbpa_pkg::CNT_W-1:0] free);
		plan_row_t row;
		row = '{1'b0, '0, '0, '0, cmd, addr, 1'b1, '{st, idx, baddr, mem, free}};
		directed_plan.push_back(row);
	endfunction

	task automatic set_pool(logic [31:0] base, logic [12:0] bytes, logic [6:0] count);
		s_tvalid <= 1'b0;
		while (alloc_replies_due.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= fbpa_pkg::REG_POOL_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= fbpa_pkg::REG_BLOCK_BYTES;
		cfg_data <= 32'(bytes);
		@(posedge clk);
		cfg_index <= fbpa_pkg::REG_BLOCKS_IN_USE;
		cfg_data <= 32'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
		map_base = base;
		map_bytes = bytes;
		map_blocks = count;
	endtask

	task automatic issue_word(logic [2:0] cmd, logic [31:0] addr, bit typed, pool_result_t want);
		pool_result_t predicted;
		while (!(words_sent >= CALM_LO && words_sent < CALM_HI) && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, addr, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = pool_predict(cmd, addr);
		alloc_replies_due.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic random_pool_setup();
		logic [31:0] base;
		logic [12:0] bytes;
		logic [6:0] count;
		case ($urandom_range(3))
		0: base = '0;
		1: base = 32'hFFFF_FFFF - $urandom_range(255);
		default: base = $urandom;
		endcase
		case ($urandom_range(5))
		0: bytes = 13'd1;
		1: bytes = 13'(1 << $urandom_range(12));
		2: bytes = 13'($urandom);
		3: bytes = 13'($urandom_range(4096, 1));
		default: bytes = 13'($urandom_range(64, 1));
		endcase
		case ($urandom_range(6))
		0: count = 7'd64;
		1: count = 7'($urandom_range(127, 65));
		2: count = 7'($urandom_range(64, 1));
		3: count = 7'($urandom);
		default: count = 7'($urandom_range(8, 1));
		endcase
		set_pool(base, bytes, count);
	endtask

	task automatic random_word();
		logic [2:0] cmd;
		logic [31:0] addr;
		logic [63:0] span;
		int unsigned k, pick;
		span = 64'(pool_blocks()) * 64'(map_bytes);
		pick = $urandom_range(99);
		addr = $urandom;
		if (pick < 35) begin
			cmd = fbpa_pkg::CMD_ALLOC;
		end else if (pick < 70) begin
			cmd = fbpa_pkg::CMD_FREE;
			k = $urandom_range(pool_blocks());
			addr = map_base + k * 32'(map_bytes);
			case ($urandom_range(9))
			0, 1: if (map_bytes > 1) addr = addr + $urandom_range(32'(map_bytes) - 1, 1);
			2: addr = $urandom;
			default: ;
			endcase
		end else if (pick < 82) begin
			cmd = fbpa_pkg::CMD_MEMBER;
			case ($urandom_range(4))
			0: addr = map_base - 1;
			1: addr = map_base;
			2: addr = map_base + span[31:0] - 1;
			3: addr = map_base + span[31:0];
			default: ;
			endcase
		end else if (pick < 92) begin
			cmd = fbpa_pkg::CMD_COUNT;
		end else if (pick < 95) begin
			cmd = fbpa_pkg::CMD_CLEAR;
		end else begin
			cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
		end
		issue_word(cmd, addr, 1'b0, '0);
	endtask

	// result side: random back-pressure, one long hold-off, checks
	initial begin
		pool_result_t got, want;
		int replies_seen;
		replies_seen = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status = fbpa_pkg::status_t'(m_tdata[2:0]);
				got.index  = m_tdata[8:3];
				got.addr   = m_tdata[40:9];
				got.member = m_tdata[41];
				got.free   = m_tdata[48:42];
				replies_seen++;
				if (alloc_replies_due.size() == 0) begin
					if (bad_words < 10)
						$display("unexpected word %h at %0t", m_tdata, $time);
					bad_words++;
				end else begin
					want = alloc_replies_due.pop_front();
					if (got.status !== want.status || got.index !== want.index ||
							got.addr !== want.addr || got.member !== want.member ||
							got.free !== want.free) begin
						if (bad_words < 10)
							$display({"mismatch at %0t: want st=%0d idx=%0d addr=%h mem=%0d ",
								"free=%0d, got st=%0d idx=%0d addr=%h mem=%0d free=%0d"},
								$time, want.status, want.index, want.addr, want.member,
								want.free, got.status, got.index, got.addr, got.member,
								got.free);
						bad_words++;
					end
				end
			end
			if (replies_seen == HOLD_AT && m_tready) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= (replies_seen >= CALM_LO && replies_seen < CALM_HI) ||
					$urandom_range(99) >= 10;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t row;
		// reset settings: base 0, 1-byte blocks, 64 blocks
		plan_known(fbpa_pkg::CMD_COUNT, 32'd0, fbpa_pkg::ST_OK, 6'd0, 32'd0, 1'b1, 7'd64);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_OK, 6'd0, 32'd0, 1'b1, 7'd63);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_OK, 6'd1, 32'd1, 1'b1, 7'd62);
		plan_known(fbpa_pkg::CMD_FREE, 32'd0, fbpa_pkg::ST_OK, 6'd0, 32'd0, 1'b1, 7'd63);
		plan_known(fbpa_pkg::CMD_FREE, 32'd0, fbpa_pkg::ST_DOUBLE, 6'd0, 32'd0, 1'b1, 7'd63);
		plan_known(fbpa_pkg::CMD_FREE, 32'd64, fbpa_pkg::ST_OUTSIDE,
			6'd0, 32'd0, 1'b0, 7'd63);
		plan_known(CMD_RSVD_HI, 32'hFFFF_FFFF, fbpa_pkg::ST_OK, 6'd0, 32'd0, 1'b0, 7'd63);
		plan_known(fbpa_pkg::CMD_CLEAR, 32'h3F, fbpa_pkg::ST_OK, 6'd0, 32'd0, 1'b1, 7'd64);
		// pool wrapping past the top of the address space
		plan_cfg(32'hFFFF_FFF0, 13'd8, 7'd4);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_OK,
			6'd0, 32'hFFFF_FFF0, 1'b1, 7'd3);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_OK,
			6'd1, 32'hFFFF_FFF8, 1'b1, 7'd2);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_OK, 6'd2, 32'd0, 1'b1, 7'd1);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_OK, 6'd3, 32'd8, 1'b1, 7'd0);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_FULL, 6'd0, 32'd0, 1'b1, 7'd0);
		plan_known(fbpa_pkg::CMD_FREE, 32'd4, fbpa_pkg::ST_MISALIGNED,
			6'd0, 32'd0, 1'b1, 7'd0);
		plan_known(fbpa_pkg::CMD_FREE, 32'd0, fbpa_pkg::ST_OK, 6'd2, 32'd0, 1'b1, 7'd1);
		plan_known(fbpa_pkg::CMD_FREE, 32'h10, fbpa_pkg::ST_OUTSIDE,
			6'd0, 32'd0, 1'b0, 7'd1);
		// zero block size, block count saturated; flags set in the old pool stay set
		plan_cfg(32'h1234_5678, 13'd0, 7'd127);
		plan_word(fbpa_pkg::CMD_ALLOC, 32'h1234_5678);
		plan_word(fbpa_pkg::CMD_FREE, 32'h1234_5678);
		plan_word(CMD_RSVD_LO, 32'd0);
		// empty pool
		plan_cfg(32'd0, 13'd4096, 7'd0);
		plan_known(fbpa_pkg::CMD_ALLOC, 32'd0, fbpa_pkg::ST_FULL, 6'd0, 32'd0, 1'b0, 7'd0);
		plan_known(fbpa_pkg::CMD_FREE, 32'd0, fbpa_pkg::ST_OUTSIDE, 6'd0, 32'd0, 1'b0, 7'd0);
		plan_known(fbpa_pkg::CMD_COUNT, 32'd0, fbpa_pkg::ST_OK, 6'd0, 32'd0, 1'b0, 7'd0);
		// widest block size
		plan_cfg(32'h8000_0000, 13'd8191, 7'd64);
		plan_word(fbpa_pkg::CMD_MEMBER, 32'h8000_0000 + 64 * 8191 - 1);
		plan_word(fbpa_pkg::CMD_FREE, 32'h8000_0000 + 63 * 8191);
		plan_word(fbpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.is_cfg)
				set_pool(row.base, row.bytes, row.count);
			else
				issue_word(row.cmd, row.addr, row.typed, row.want);
		end
		for (int p = 0; p < RAND_PHASES; p++) begin
			random_pool_setup();
			for (int j = 0; j < PHASE_WORDS; j++)
				random_word();
		end

		s_tvalid <= 1'b0;
		while (alloc_replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_words == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
sv/fbpa_pkg.sv
sv/fixed_block_pool_allocator.sv
tb/tb.sv
